// ===== rtl/snpv_pkg.sv =====
// Package for the signed nibble-prefix varint decoder.
// Field widths, flag-byte constants and the flag count decode function.
// No dependencies.
`default_nettype none

package snpv_pkg;

	localparam int BYTE_W  = 8;
	localparam int VALUE_W = 64;
	localparam int CNT_W   = 4;
	localparam int NIB_W   = 4;

	// High nibble values above this mark a negative number
	localparam logic [NIB_W-1:0] NEG_OFFSET = 4'd8;
	localparam logic [NIB_W-1:0] NIBBLE_ZERO = 4'd0;

	typedef logic [CNT_W-1:0] cnt_t;

	// Flag decode: byte count and sign taken from the high nibble
	typedef struct packed {
		cnt_t count;
		logic neg;
	} flag_t;

	function automatic flag_t decode_flag(input logic [NIB_W-1:0] hi);
		flag_t f;
		f.neg = (hi > NEG_OFFSET);
		f.count = f.neg ? cnt_t'(hi - NEG_OFFSET) : cnt_t'(hi);
		return f;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/signed_nibble_prefix_varint_decoder_top.sv =====
// Top level of the signed nibble-prefix varint decoder.
// Depends on snpv_pkg for widths, flag constants and the flag decode.
// Holds the input register, the decode state and the result register.
`default_nettype none

// Decodes one stream byte per cycle while not stalled. A byte is transferred
// into an input register; when it advances it is folded into the decode state
// and, if it completes an integer, the value lands in the result register.
// A flag byte with a zero count, or with a count of one and a nonzero low
// nibble, completes on its own. in_stall rises only while both the input
// register and the result register hold work and the result is stalled
// downstream.
module signed_nibble_prefix_varint_decoder_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [snpv_pkg::BYTE_W-1:0]         byte_in,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [snpv_pkg::VALUE_W-1:0]      value
);

	logic                          valid_s1;
	logic [snpv_pkg::BYTE_W-1:0]   byte_s1;

	snpv_pkg::cnt_t                bytes_left_q;
	logic [snpv_pkg::VALUE_W-1:0]  acc_q;
	logic                          neg_q;

	logic                          out_valid_q;
	logic [snpv_pkg::VALUE_W-1:0]  value_q;

	logic                          out_free;
	logic                          advance;
	logic                          in_take;

	// Next-state and result of the byte in the input register
	snpv_pkg::flag_t               flag;
	logic [snpv_pkg::NIB_W-1:0]    lo;
	snpv_pkg::cnt_t                bl_nx;
	logic [snpv_pkg::VALUE_W-1:0]  acc_nx;
	logic                          neg_nx;
	logic                          emit;
	logic [snpv_pkg::VALUE_W-1:0]  mag;
	logic                          mag_neg;
	logic [snpv_pkg::VALUE_W-1:0]  result;

	// Handshake: s1 moves on when the result register is free or draining
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_take   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign value     = value_q;

	// Decode of one byte
	always_comb begin
		flag    = snpv_pkg::decode_flag(byte_s1[snpv_pkg::BYTE_W-1 -: snpv_pkg::NIB_W]);
		lo      = byte_s1[snpv_pkg::NIB_W-1:0];
		bl_nx   = bytes_left_q;
		acc_nx  = acc_q;
		neg_nx  = neg_q;
		emit    = 1'b0;
		mag     = '0;
		mag_neg = 1'b0;
		if (bytes_left_q == '0) begin
			if (flag.count == '0) begin
				// zero flag or empty count: value 0 at once
				emit   = 1'b1;
				acc_nx = '0;
				neg_nx = 1'b0;
			end else if (lo != snpv_pkg::NIBBLE_ZERO && flag.count == snpv_pkg::cnt_t'(1)) begin
				// low nibble alone carries the whole magnitude
				emit    = 1'b1;
				mag     = snpv_pkg::VALUE_W'(lo);
				mag_neg = flag.neg;
				acc_nx  = '0;
				neg_nx  = 1'b0;
			end else begin
				bl_nx  = (lo != snpv_pkg::NIBBLE_ZERO) ? flag.count - 1'b1 : flag.count;
				acc_nx = snpv_pkg::VALUE_W'(lo);
				neg_nx = flag.neg;
			end
		end else begin
			// payload byte: shift in, most significant first
			mag = {acc_q[snpv_pkg::VALUE_W-snpv_pkg::BYTE_W-1:0], byte_s1};
			bl_nx = bytes_left_q - 1'b1;
			if (bytes_left_q == snpv_pkg::cnt_t'(1)) begin
				emit    = 1'b1;
				mag_neg = neg_q;
				acc_nx  = '0;
				neg_nx  = 1'b0;
			end else begin
				acc_nx = mag;
			end
		end
		result = mag_neg ? (~mag + 1'b1) : mag;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= byte_in;
		end
	end

	// Decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			acc_q        <= '0;
			neg_q        <= 1'b0;
		end else if (advance) begin
			bytes_left_q <= bl_nx;
			acc_q        <= acc_nx;
			neg_q        <= neg_nx;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			value_q <= result;
		end
	end

`ifndef SYNTHESIS
	// Count never exceeds the largest flag count
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_left_q <= snpv_pkg::cnt_t'(snpv_pkg::NEG_OFFSET))
		else $error("bytes_left out of range");

	// Stall only while the input register is occupied and the result is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without cause");

	// Between integers the accumulator and sign are clear
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(bytes_left_q == '0) |-> (acc_q == '0 && !neg_q))
		else $error("stale accumulator between integers");

	// A held result does not get overwritten
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(value_q)))
		else $error("stalled result lost");
`endif

endmodule

`default_nettype wire
